[design/burkes_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// burkes_pkg
// Shared types and constants for the Burkes error-diffusion dither block.
// ---------------------------------------------------------------------------
package burkes_pkg;

	// Largest supported image row, in pixels
	localparam int DEFAULT_MAX_WIDTH = 2048;

	// Register file layout
	localparam int REG_ADDR_W = 4;
	localparam int REG_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_FIRST_ROW    = 2'd2,
		REG_END_ROW      = 2'd3
	} reg_index_t;

	// Register reset values
	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
	localparam logic [15:0] RST_FIRST_ROW    = 16'd0;
	localparam logic [15:0] RST_END_ROW      = 16'd480;

	// Output levels
	localparam logic [7:0] PIX_WHITE = 8'd255;
	localparam logic [7:0] PIX_BLACK = 8'd0;

	// Per-pixel position info computed at the input side
	typedef struct packed {
		logic fsr;     // first row of the strip: no error from above
		logic down;    // downward diffusion allowed on this row
		logic has_l1;  // column x-1 exists
		logic has_l2;  // column x-2 exists
		logic has_r1;  // column x+1 exists (clear on the row-end pixel)
		logic has_r2;  // column x+2 exists
		logic last;    // final pixel of the strip
	} scan_flags_t;

endpackage : burkes_pkg
`default_nettype wire

[design/burkes_cfg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// burkes_cfg
// APB-style register file holding the image geometry and strip bounds.
// ---------------------------------------------------------------------------
module burkes_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [burkes_pkg::REG_ADDR_W-1:0]   paddr,
	input  wire logic [burkes_pkg::REG_DATA_W-1:0]   pwdata,
	output logic      [burkes_pkg::REG_DATA_W-1:0]   prdata,
	output logic                                     pready,
	output logic      [11:0]                         image_width,
	output logic      [15:0]                         image_height,
	output logic      [15:0]                         first_row,
	output logic      [15:0]                         end_row
);
	import burkes_pkg::*;

	logic       wr_en;
	reg_index_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_index_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width  <= RST_IMAGE_WIDTH;
			image_height <= RST_IMAGE_HEIGHT;
			first_row    <= RST_FIRST_ROW;
			end_row      <= RST_END_ROW;
		end else if (wr_en) begin
			unique case (idx)
				REG_IMAGE_WIDTH:  image_width  <= pwdata[11:0];
				REG_IMAGE_HEIGHT: image_height <= pwdata[15:0];
				REG_FIRST_ROW:    first_row    <= pwdata[15:0];
				REG_END_ROW:      end_row      <= pwdata[15:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_IMAGE_WIDTH:  prdata = REG_DATA_W'(image_width);
			REG_IMAGE_HEIGHT: prdata = REG_DATA_W'(image_height);
			REG_FIRST_ROW:    prdata = REG_DATA_W'(first_row);
			REG_END_ROW:      prdata = REG_DATA_W'(end_row);
		endcase
	end

endmodule : burkes_cfg
`default_nettype wire

[design/burkes_scan.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// burkes_scan
// Raster position tracker: column, row and strip bookkeeping per transfer.
// ---------------------------------------------------------------------------
module burkes_scan #(
	parameter int MAX_WIDTH = burkes_pkg::DEFAULT_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [11:0]             image_width,
	input  wire logic [15:0]             image_height,
	input  wire logic [15:0]             first_row,
	input  wire logic [15:0]             end_row,
	output logic      [AW-1:0]           col,
	output burkes_pkg::scan_flags_t      flags
);
	import burkes_pkg::*;

	localparam int WW = AW + 1;
	localparam int CW = (WW > 12) ? WW : 12;

	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	logic          fsr_q;

	logic [CW-1:0] iw_ext;
	logic [WW-1:0] width;
	logic [WW-1:0] x1, x2;
	logic [15:0]   row_eff;
	logic [16:0]   row_nxt;
	logic [15:0]   stop0;
	logic [16:0]   stop;
	logic          row_end;

	// clamp the configured width to 1..MAX_WIDTH
	always_comb begin
		iw_ext = CW'(image_width);
		if (iw_ext == '0)
			width = WW'(1);
		else if (iw_ext > CW'(MAX_WIDTH))
			width = WW'(MAX_WIDTH);
		else
			width = WW'(iw_ext);
	end

	// strip end row
	always_comb begin
		stop0 = (end_row < image_height) ? end_row : image_height;
		if (stop0 <= first_row)
			stop = {1'b0, first_row} + 17'd1;
		else
			stop = {1'b0, stop0};
	end

	// position flags for the pixel now offered
	always_comb begin
		x1      = {1'b0, col_q} + WW'(1);
		x2      = {1'b0, col_q} + WW'(2);
		row_eff = (fsr_q && col_q == '0) ? first_row : row_q;
		row_nxt = {1'b0, row_eff} + 17'd1;
		row_end = !(x1 < width);

		flags.fsr    = fsr_q;
		flags.down   = row_nxt < {1'b0, image_height};
		flags.has_l1 = col_q != '0;
		flags.has_l2 = col_q > AW'(1);
		flags.has_r1 = !row_end;
		flags.has_r2 = x2 < width;
		flags.last   = row_end && (row_nxt >= stop);
	end

	assign col = col_q;

	// advance on every accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= RST_FIRST_ROW;
			fsr_q <= 1'b1;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				fsr_q <= flags.last;
				row_q <= flags.last ? first_row : row_nxt[15:0];
			end else begin
				col_q <= x1[AW-1:0];
				row_q <= row_eff;
			end
		end
	end

endmodule : burkes_scan
`default_nettype wire

[design/burkes_line_mem.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// burkes_line_mem
// Line buffer of next-row error sums, one write and one registered read.
// A write landing on the address read in the same cycle is forwarded.
// ---------------------------------------------------------------------------
module burkes_line_mem #(
	parameter int MAX_WIDTH = burkes_pkg::DEFAULT_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire logic signed [8:0]   wr_data,
	output logic signed [8:0]        rd_data
);
	logic signed [8:0] mem [MAX_WIDTH];
	logic signed [8:0] rd_q;
	logic signed [8:0] fwd_q;
	logic              fwd_sel_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			fwd_q <= wr_data;
		end
	end

	// forward select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_sel_q <= 1'b0;
		else if (rd_en)
			fwd_sel_q <= wr_en && (wr_addr == rd_addr);
	end

	assign rd_data = fwd_sel_q ? fwd_q : rd_q;

endmodule : burkes_line_mem
`default_nettype wire

[design/burkes_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// burkes_core
// Input register, threshold and Burkes diffusion, and output register.
// Holds the same-row carries, the next-row window and the two row-tail sums.
// ---------------------------------------------------------------------------
module burkes_core #(
	parameter int MAX_WIDTH = burkes_pkg::DEFAULT_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [7:0]              pixel_value,
	input  wire logic [AW-1:0]           col,
	input  wire burkes_pkg::scan_flags_t flags,
	output logic                         busy,
	input  wire logic signed [8:0]       line_rd,
	output logic                         line_wr_en,
	output logic      [AW-1:0]           line_wr_addr,
	output logic signed [8:0]            line_wr_data,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic      [7:0]              out_pixel,
	output logic                         strip_last
);
	import burkes_pkg::*;

	// signed division by 2**sh, truncated toward zero
	function automatic logic signed [8:0] div_trunc(input logic signed [8:0] v,
	                                               input logic [2:0] sh);
		logic signed [8:0] bias;
		bias = v[8] ? ((9'sd1 <<< sh) - 9'sd1) : 9'sd0;
		return (v + bias) >>> sh;
	endfunction

	// stage 1
	logic              valid_s1;
	logic [7:0]        pix_s1;
	logic [AW-1:0]     col_s1;
	scan_flags_t       flags_s1;

	// diffusion state
	logic signed [8:0] rc0_q, rc1_q;
	logic signed [8:0] bw0_q, bw1_q, bw2_q, bw3_q;
	logic signed [8:0] tail_a_q, tail_b_q;

	// output register
	logic              out_valid_q;
	logic [7:0]        out_pixel_q;
	logic              strip_last_q;

	logic              advance;
	logic signed [8:0] below;
	logic signed [10:0] csum;
	logic [7:0]        cval;
	logic [7:0]        outv;
	logic signed [8:0] err, q4, q8, q16;
	logic signed [8:0] rc0_d, rc1_d;
	logic signed [8:0] w0_d, w1_d, w2_d, w3_d, w4_d;

	assign advance = valid_s1 && (!out_valid_q || !result_stall);
	assign busy    = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixel_value;
			col_s1   <= col;
			flags_s1 <= flags;
		end
	end

	// corrected value, threshold and error shares
	always_comb begin
		if (flags_s1.fsr)
			below = 9'sd0;
		else if (!flags_s1.has_r1)
			below = tail_b_q;
		else if (!flags_s1.has_r2)
			below = tail_a_q;
		else
			below = line_rd;

		csum = $signed({3'b000, pix_s1}) + 11'(rc0_q) + 11'(below);
		if (csum < 11'sd0)
			cval = 8'd0;
		else if (csum > 11'sd255)
			cval = 8'd255;
		else
			cval = csum[7:0];

		outv = cval[7] ? PIX_WHITE : PIX_BLACK;
		err  = cval[7] ? ($signed({1'b0, cval}) - 9'sd255) : $signed({1'b0, cval});
		q4   = div_trunc(err, 3'd2);
		q8   = div_trunc(err, 3'd3);
		q16  = div_trunc(err, 3'd4);
	end

	// same-row and next-row shares
	always_comb begin
		rc0_d = rc1_q + (flags_s1.has_r1 ? q4 : 9'sd0);
		rc1_d = flags_s1.has_r2 ? q8 : 9'sd0;
		w0_d  = bw0_q + ((flags_s1.down && flags_s1.has_l2) ? q16 : 9'sd0);
		w1_d  = bw1_q + ((flags_s1.down && flags_s1.has_l1) ? q8 : 9'sd0);
		w2_d  = bw2_q + (flags_s1.down ? q4 : 9'sd0);
		w3_d  = bw3_q + ((flags_s1.down && flags_s1.has_r1) ? q8 : 9'sd0);
		w4_d  = (flags_s1.down && flags_s1.has_r2) ? q16 : 9'sd0;
	end

	// finished column x-2 goes to the line buffer
	assign line_wr_en   = advance && flags_s1.has_l2;
	assign line_wr_addr = col_s1 - AW'(2);
	assign line_wr_data = w0_d;

	// carries and window, cleared at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc0_q <= '0;
			rc1_q <= '0;
			bw0_q <= '0;
			bw1_q <= '0;
			bw2_q <= '0;
			bw3_q <= '0;
		end else if (advance) begin
			if (!flags_s1.has_r1) begin
				rc0_q <= '0;
				rc1_q <= '0;
				bw0_q <= '0;
				bw1_q <= '0;
				bw2_q <= '0;
				bw3_q <= '0;
			end else begin
				rc0_q <= rc0_d;
				rc1_q <= rc1_d;
				bw0_q <= w1_d;
				bw1_q <= w2_d;
				bw2_q <= w3_d;
				bw3_q <= w4_d;
			end
		end
	end

	// last two columns of the row are kept in registers
	always_ff @(posedge clk) begin
		if (advance && !flags_s1.has_r1) begin
			tail_b_q <= w2_d;
			if (flags_s1.has_l1)
				tail_a_q <= w1_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pixel_q  <= outv;
			strip_last_q <= flags_s1.last;
		end
	end

	assign result_valid = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign strip_last   = strip_last_q;

endmodule : burkes_core
`default_nettype wire

[design/burkes_error_diffusion_dither.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// burkes_error_diffusion_dither
// Burkes error-diffusion dither of an 8-bit gray strip to black and white.
//
//   channel   handshake                     payload
//   -------   ---------------------------   ------------------------
//   pixel     pixel_valid / pixel_stall     pixel_value
//   result    result_valid / result_stall   out_pixel, strip_last
//   config    psel/penable/pwrite, pready   paddr, pwdata / prdata
//
// One pixel per cycle sustained while result_stall is low; an accepted
// transfer passes the input register and then the output register.
// The carry loop is one add-clamp-shift path in the diffusion stage.
// Reset clears the carries, window and position; no line buffer clear.
// A stalled result holds its register; a new pixel is still taken while
// the input register is free or moves on in the same cycle.
// ---------------------------------------------------------------------------
module burkes_error_diffusion_dither #(
	parameter int MAX_WIDTH = burkes_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [burkes_pkg::REG_ADDR_W-1:0]   paddr,
	input  wire logic [burkes_pkg::REG_DATA_W-1:0]   pwdata,
	output logic      [burkes_pkg::REG_DATA_W-1:0]   prdata,
	output logic                                     pready,
	input  wire logic                                pixel_valid,
	output logic                                     pixel_stall,
	input  wire logic [7:0]                          pixel_value,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic      [7:0]                          out_pixel,
	output logic                                     strip_last
);
	import burkes_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [11:0]       image_width;
	logic [15:0]       image_height;
	logic [15:0]       first_row;
	logic [15:0]       end_row;
	logic              accept;
	logic              busy;
	logic [AW-1:0]     col;
	scan_flags_t       flags;
	logic signed [8:0] line_rd;
	logic              line_wr_en;
	logic [AW-1:0]     line_wr_addr;
	logic signed [8:0] line_wr_data;

	assign pixel_stall = busy;
	assign accept      = pixel_valid && !busy;

	// registers
	burkes_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.image_width  (image_width),
		.image_height (image_height),
		.first_row    (first_row),
		.end_row      (end_row)
	);

	// raster position
	burkes_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.image_width  (image_width),
		.image_height (image_height),
		.first_row    (first_row),
		.end_row      (end_row),
		.col          (col),
		.flags        (flags)
	);

	// next-row error line
	burkes_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (line_wr_en),
		.wr_addr (line_wr_addr),
		.wr_data (line_wr_data),
		.rd_data (line_rd)
	);

	// threshold and diffusion
	burkes_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pixel_value  (pixel_value),
		.col          (col),
		.flags        (flags),
		.busy         (busy),
		.line_rd      (line_rd),
		.line_wr_en   (line_wr_en),
		.line_wr_addr (line_wr_addr),
		.line_wr_data (line_wr_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_pixel    (out_pixel),
		.strip_last   (strip_last)
	);

endmodule : burkes_error_diffusion_dither
`default_nettype wire
